>>> rtl/core/srm_pkg.sv
`timescale 1ns / 1ps
// srm_pkg: types and constants of the sccb register access master
// no dependencies; imported by srm_step and sccb_register_access_master_core

package srm_pkg;

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_START_A = 3'd1;
    localparam logic [2:0] PH_START_B = 3'd2;
    localparam logic [2:0] PH_LOW     = 3'd3;
    localparam logic [2:0] PH_HIGH    = 3'd4;
    localparam logic [2:0] PH_STOP_A  = 3'd5;
    localparam logic [2:0] PH_STOP_B  = 3'd6;
    localparam logic [2:0] PH_STOP_C  = 3'd7;

    // byte slots of a transaction
    localparam logic [1:0] BYTE_ADDR  = 2'd0;
    localparam logic [1:0] BYTE_REG   = 2'd1;
    localparam logic [1:0] BYTE_THIRD = 2'd2;
    localparam logic [1:0] BYTE_READ  = 2'd3;

    localparam logic       OP_WRITE   = 1'b0;
    localparam logic       OP_READ    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_TIME  = 2'd0;
    localparam logic [1:0] CFG_HIGH_TIME = 2'd1;
    localparam logic [1:0] CFG_DEV_ADDR  = 2'd2;

    localparam logic [15:0] LOW_TIME_RST  = 16'd100;
    localparam logic [15:0] HIGH_TIME_RST = 16'd50;
    localparam logic [6:0]  DEV_ADDR_RST  = 7'd33;

    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       request;
        logic       operation;
        logic [7:0] sub_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       ok;
        logic [7:0] read_data;
    } t_out;

    typedef struct packed {
        logic [15:0] low_time;
        logic [15:0] high_time;
        logic [6:0]  device_address;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] tick_count;
        logic [3:0]  bit_count;
        logic [1:0]  byte_index;
        logic [7:0]  shift_byte;
        logic        lat_op;
        logic [7:0]  lat_reg;
        logic [7:0]  lat_data;
        logic        all_acked;
    } t_state;

endpackage

>>> rtl/core/srm_step.sv
`timescale 1ns / 1ps
// srm_step: one tick of the bus sequencer, next state and line levels
// depends on srm_pkg

module srm_step
    import srm_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_in    i_item,
    output t_state o_state,
    output t_out   o_result
);

    t_state      w;
    t_state      nx;
    t_out        res;
    logic        sda_bit;
    logic [15:0] len_lo;
    logic [15:0] len_hi;
    logic [15:0] len;
    logic        phase_end;

    assign len_lo = (i_cfg.low_time == 16'd0) ? 16'd1 : i_cfg.low_time;
    assign len_hi = (i_cfg.high_time == 16'd0) ? 16'd1 : i_cfg.high_time;

    always_comb begin
        w = i_state;
        // a request is taken only when idle, and its tick is the first of start
        if (i_state.phase == PH_IDLE && i_item.request) begin
            w.lat_op     = i_item.operation;
            w.lat_reg    = i_item.sub_addr;
            w.lat_data   = i_item.write_data;
            w.all_acked  = 1'b1;
            w.byte_index = BYTE_ADDR;
            w.bit_count  = 4'd0;
            w.shift_byte = 8'd0;
            w.phase      = PH_START_A;
            w.tick_count = 16'd0;
        end

        len       = (w.phase == PH_LOW || w.phase == PH_STOP_A) ? len_lo : len_hi;
        phase_end = ({1'b0, w.tick_count} + 17'd1) >= {1'b0, len};
        sda_bit   = (w.byte_index != BYTE_READ && w.bit_count < BITS_PER_BYTE)
                    ? w.shift_byte[7] : 1'b1;

        nx  = w;
        res = '0;

        unique case (w.phase)
            PH_IDLE: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
            PH_START_A: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
            PH_START_B: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            PH_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = sda_bit;
            end
            PH_HIGH: begin
                res.scl_level = 1'b1;
                res.sda_level = sda_bit;
            end
            PH_STOP_A: begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            PH_STOP_B: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            PH_STOP_C: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b1;
            end
        endcase

        if (w.phase != PH_IDLE) begin
            res.busy_res = 1'b1;
            if (!phase_end) begin
                nx.tick_count = w.tick_count + 16'd1;
            end else begin
                nx.tick_count = 16'd0;
                unique case (w.phase)
                    PH_START_A: nx.phase = PH_START_B;
                    PH_START_B: begin
                        // repeated start of a read is followed by the read address
                        nx.shift_byte = {i_cfg.device_address,
                                         (w.byte_index == BYTE_THIRD)};
                        nx.bit_count  = 4'd0;
                        nx.phase      = PH_LOW;
                    end
                    PH_LOW: nx.phase = PH_HIGH;
                    PH_HIGH: begin
                        priority if (w.bit_count < BITS_PER_BYTE) begin
                            nx.shift_byte = {w.shift_byte[6:0],
                                             (w.byte_index == BYTE_READ) & i_item.sda_in};
                            nx.bit_count  = w.bit_count + 4'd1;
                            nx.phase      = PH_LOW;
                        end else if (w.byte_index == BYTE_READ) begin
                            nx.phase = PH_STOP_A;
                        end else if (i_item.sda_in) begin
                            // nack aborts to stop
                            nx.all_acked  = 1'b0;
                            nx.shift_byte = 8'd0;
                            nx.phase      = PH_STOP_A;
                        end else if (w.byte_index == BYTE_ADDR) begin
                            nx.byte_index = BYTE_REG;
                            nx.shift_byte = w.lat_reg;
                            nx.bit_count  = 4'd0;
                            nx.phase      = PH_LOW;
                        end else if (w.byte_index == BYTE_REG) begin
                            nx.byte_index = BYTE_THIRD;
                            nx.bit_count  = 4'd0;
                            if (w.lat_op == OP_WRITE) begin
                                nx.shift_byte = w.lat_data;
                                nx.phase      = PH_LOW;
                            end else begin
                                nx.phase      = PH_START_A;
                            end
                        end else if (w.lat_op == OP_WRITE) begin
                            nx.shift_byte = 8'd0;
                            nx.phase      = PH_STOP_A;
                        end else begin
                            nx.byte_index = BYTE_READ;
                            nx.shift_byte = 8'd0;
                            nx.bit_count  = 4'd0;
                            nx.phase      = PH_LOW;
                        end
                    end
                    PH_STOP_A: nx.phase = PH_STOP_B;
                    PH_STOP_B: nx.phase = PH_STOP_C;
                    PH_STOP_C: begin
                        res.done_res  = 1'b1;
                        res.ok        = w.all_acked;
                        res.read_data = (w.all_acked && w.lat_op == OP_READ)
                                        ? w.shift_byte : 8'd0;
                        nx.phase      = PH_IDLE;
                    end
                    PH_IDLE: nx.phase = PH_IDLE;
                endcase
            end
        end
    end

    assign o_state  = nx;
    assign o_result = res;

endmodule

>>> rtl/core/sccb_register_access_master_core.sv
`timescale 1ns / 1ps
// sccb_register_access_master_core: top level, state, config and result registers
// depends on srm_pkg and srm_step
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------------
//  in        input      i_in_valid / o_in_ready      i_in   (t_in: request, sda tick)
//  out       output     o_out_valid / i_out_ready    o_out  (t_out: scl, sda, status)
//  cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  one transaction on the in channel is one bus tick; it yields exactly one result
//  each tick is handled combinationally: sequencer state -> srm_step -> result register
//  a new tick is accepted every cycle while the result register is empty or being taken
//  a stalled output holds the result register and blocks input; state only advances on accept
//  reset (synchronous, active low) returns to idle with lines high and default timing
//  the config port is always ready and writes go straight into the config registers

module sccb_register_access_master_core
    import srm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;
    t_cfg   r_cfg;
    t_out   r_out;
    t_out   n_out;
    logic   r_out_valid;
    logic   in_fire;
    logic   cfg_fire;

    // output register frees up in the same cycle it is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    // one tick of the sequencer
    srm_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // config registers, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_time       <= LOW_TIME_RST;
            r_cfg.high_time      <= HIGH_TIME_RST;
            r_cfg.device_address <= DEV_ADDR_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                CFG_LOW_TIME:  r_cfg.low_time       <= i_cfg_data;
                CFG_HIGH_TIME: r_cfg.high_time      <= i_cfg_data;
                CFG_DEV_ADDR:  r_cfg.device_address <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a finished transaction leaves the sequencer idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_out.done_res |=> r_state.phase == PH_IDLE)
        else $error("sequencer not idle after done");

    // the last stop tick releases both lines
    a_done_lines_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.scl_level && r_out.sda_level && r_out.busy_res)
        else $error("done without both lines released");

    // status fields are quiet outside done
    a_quiet_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> !r_out.ok && r_out.read_data == 8'd0)
        else $error("ok or read data outside done");

    // only a read reaches the data-in byte
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_index == BYTE_READ |-> r_state.lat_op == OP_READ
                                            && r_state.bit_count <= BITS_PER_BYTE)
        else $error("read byte slot in a write");

endmodule
